// File: rtl/crcfr_pkg.sv
package crcfr_pkg;

    localparam logic [7:0]  MAX_LENGTH_RST = 8'd20;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] CRC_INIT       = 16'h0000;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_LEN     = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CRC_LO  = 2'd3
    } t_rx_phase;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_DATA    = 3'd1,
        EV_GOOD    = 3'd2,
        EV_CRC_BAD = 3'd3,
        EV_LEN_REJ = 3'd4
    } t_event;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] data_byte;
        logic [7:0] frame_cmd;
        logic [7:0] frame_len;
        logic       fail_count;
        logic       resync;
    } t_result;

    // reflected crc-16, one byte
    function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/crcfr_in_if.sv
interface crcfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/crcfr_out_if.sv
interface crcfr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic [7:0] frame_cmd;
    logic [7:0] frame_len;
    logic       fail_count;
    logic       resync;

    modport source (
        output valid, output event_res, output data_byte, output frame_cmd,
        output frame_len, output fail_count, output resync, input ready
    );
    modport sink (
        input valid, input event_res, input data_byte, input frame_cmd,
        input frame_len, input fail_count, input resync, output ready
    );
endinterface

// File: rtl/crcfr_cfg_if.sv
interface crcfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] max_length;

    modport source (output valid, output max_length, input ready);
    modport sink   (input valid, input max_length, output ready);
endinterface

// File: rtl/crcfr_core.sv
module crcfr_core #(
    parameter logic [7:0] P_MAX_LENGTH_RST = crcfr_pkg::MAX_LENGTH_RST
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_max_length,
    input  logic                i_take,
    input  logic [7:0]          i_rx_byte,
    output crcfr_pkg::t_result  o_result
);

    crcfr_pkg::t_rx_phase r_phase, n_phase;
    logic [7:0]  r_max_length;
    logic [7:0]  r_remaining, n_remaining;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_high, n_crc_high;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_len, n_len;
    logic        r_fail, n_fail;

    logic [15:0] crc_seed;
    logic [15:0] crc_upd;
    logic        len_bad;
    logic        crc_match;

    assign crc_seed  = (r_phase == crcfr_pkg::PH_START) ? crcfr_pkg::CRC_INIT : r_crc;
    assign crc_upd   = crcfr_pkg::crc_arc_byte(crc_seed, i_rx_byte);
    assign len_bad   = i_rx_byte > r_max_length;
    assign crc_match = r_crc == {r_crc_high, i_rx_byte};

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            crcfr_pkg::PH_START: begin
                if (i_rx_byte != 8'd0) begin
                    n_phase = crcfr_pkg::PH_LEN;
                end
            end
            crcfr_pkg::PH_LEN: begin
                n_phase = len_bad ? crcfr_pkg::PH_START : crcfr_pkg::PH_PAYLOAD;
            end
            crcfr_pkg::PH_PAYLOAD: begin
                if (r_remaining == 8'd0) begin
                    n_phase = crcfr_pkg::PH_CRC_LO;
                end
            end
            crcfr_pkg::PH_CRC_LO: begin
                n_phase = crcfr_pkg::PH_START;
            end
            default: begin
                n_phase = crcfr_pkg::PH_START;
            end
        endcase
    end

    // datapath and result
    always_comb begin
        n_remaining = r_remaining;
        n_crc       = r_crc;
        n_crc_high  = r_crc_high;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_fail      = r_fail;
        o_result.event_res = crcfr_pkg::EV_NONE;
        o_result.data_byte = 8'd0;
        o_result.resync    = 1'b0;
        case (r_phase)
            crcfr_pkg::PH_START: begin
                if (i_rx_byte != 8'd0) begin
                    n_cmd = i_rx_byte;
                    n_crc = crc_upd;
                end else begin
                    n_fail = 1'b0;
                end
            end
            crcfr_pkg::PH_LEN: begin
                n_remaining = i_rx_byte;
                if (len_bad) begin
                    o_result.event_res = crcfr_pkg::EV_LEN_REJ;
                end else begin
                    n_len = i_rx_byte;
                    n_crc = crc_upd;
                end
            end
            crcfr_pkg::PH_PAYLOAD: begin
                if (r_remaining != 8'd0) begin
                    n_remaining        = r_remaining - 8'd1;
                    n_crc              = crc_upd;
                    o_result.event_res = crcfr_pkg::EV_DATA;
                    o_result.data_byte = i_rx_byte;
                end else begin
                    n_crc_high = i_rx_byte;
                end
            end
            crcfr_pkg::PH_CRC_LO: begin
                if (crc_match) begin
                    n_fail             = 1'b0;
                    o_result.event_res = crcfr_pkg::EV_GOOD;
                end else begin
                    o_result.event_res = crcfr_pkg::EV_CRC_BAD;
                    o_result.resync    = r_fail;
                    n_fail             = ~r_fail;
                end
            end
            default: begin
                n_fail = r_fail;
            end
        endcase
        o_result.frame_cmd  = n_cmd;
        o_result.frame_len  = (o_result.event_res == crcfr_pkg::EV_LEN_REJ) ? i_rx_byte : n_len;
        o_result.fail_count = n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= P_MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_max_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= crcfr_pkg::PH_START;
            r_remaining <= 8'd0;
            r_crc       <= crcfr_pkg::CRC_INIT;
            r_crc_high  <= 8'd0;
            r_cmd       <= 8'd0;
            r_len       <= 8'd0;
            r_fail      <= 1'b0;
        end else if (i_take) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_crc       <= n_crc;
            r_crc_high  <= n_crc_high;
            r_cmd       <= n_cmd;
            r_len       <= n_len;
            r_fail      <= n_fail;
        end
    end

endmodule

// File: rtl/crcfr_out_stage.sv
module crcfr_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  crcfr_pkg::t_result i_result,
    input  logic               i_ready,
    output logic               o_can_take,
    output logic               o_valid,
    output crcfr_pkg::t_result o_result
);

    logic               r_valid;
    crcfr_pkg::t_result r_result;

    // a beat may enter when the slot is empty or drains this cycle
    assign o_can_take = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_result <= i_result;
        end
    end

endmodule

// File: rtl/crc16_serial_frame_receiver_top.sv
// a result beat is registered and appears in the cycle after its input beat is accepted
// throughput: one input beat per cycle while the output register can take it; the byte crc update is combinational
// an input beat is taken whenever the output register is empty or being read
// reset: synchronous, active low; parser idle, crc and failure count cleared
// max_length returns to its default of 20 on reset
module crc16_serial_frame_receiver_top #(
    parameter logic [7:0] P_MAX_LENGTH_RST = crcfr_pkg::MAX_LENGTH_RST
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    crcfr_in_if.sink     i_in,
    crcfr_cfg_if.sink    i_cfg,
    crcfr_out_if.source  o_out
);

    crcfr_pkg::t_result core_result;
    crcfr_pkg::t_result out_result;
    logic               can_take;
    logic               take;

    assign i_in.ready  = can_take;
    assign take        = i_in.valid && can_take;
    assign i_cfg.ready = 1'b1;

    crcfr_core #(
        .P_MAX_LENGTH_RST (P_MAX_LENGTH_RST)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_max_length (i_cfg.max_length),
        .i_take           (take),
        .i_rx_byte        (i_in.rx_byte),
        .o_result         (core_result)
    );

    crcfr_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_result   (core_result),
        .i_ready    (o_out.ready),
        .o_can_take (can_take),
        .o_valid    (o_out.valid),
        .o_result   (out_result)
    );

    assign o_out.event_res  = out_result.event_res;
    assign o_out.data_byte  = out_result.data_byte;
    assign o_out.frame_cmd  = out_result.frame_cmd;
    assign o_out.frame_len  = out_result.frame_len;
    assign o_out.fail_count = out_result.fail_count;
    assign o_out.resync     = out_result.resync;

    a_beat_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> o_out.valid)
        else $error("accepted beat produced no result");

    a_resync_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.resync |->
            o_out.event_res == crcfr_pkg::EV_CRC_BAD && !o_out.fail_count)
        else $error("resync without crc mismatch or with failure count set");

    a_data_only_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.event_res != crcfr_pkg::EV_DATA |-> o_out.data_byte == 8'd0)
        else $error("data byte set outside a payload beat");

endmodule

// File: bench/crcfr_checker.sv
`timescale 1ns / 1ps

module crcfr_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    crcfr_in_if   i_in_mon,
    crcfr_cfg_if  i_cfg_mon,
    crcfr_out_if  i_out_mon,
    output int    o_errors,
    output int    o_pending
);

    localparam int PRINT_CAP = 200;

    crcfr_pkg::t_rx_phase phase;
    logic [7:0]           len_limit;
    logic [7:0]           left;
    logic [7:0]           hi_byte;
    logic [7:0]           cmd_q;
    logic [7:0]           len_q;
    logic [15:0]          crc_acc;
    logic [1:0]           fails;
    crcfr_pkg::t_result   frame_events_q[$];
    int                   n_bad = 0;

    assign o_errors = n_bad;

    function automatic logic [15:0] arc_fold(input logic [15:0] seed, input logic [7:0] b);
        logic [15:0] acc;
        logic        lsb;
        acc = seed ^ {8'h00, b};
        repeat (8) begin
            lsb = acc[0];
            acc = {1'b0, acc[15:1]};
            if (lsb) begin
                acc = acc ^ crcfr_pkg::CRC_POLY;
            end
        end
        return acc;
    endfunction

    task automatic report(input string msg);
        if (n_bad < PRINT_CAP) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        n_bad++;
    endtask

    task automatic parse_byte(input logic [7:0] b, output crcfr_pkg::t_result r);
        r = '0;
        r.event_res = crcfr_pkg::EV_NONE;
        case (phase)
            crcfr_pkg::PH_START: begin
                if (b != 8'h00) begin
                    phase   = crcfr_pkg::PH_LEN;
                    cmd_q   = b;
                    crc_acc = arc_fold(crcfr_pkg::CRC_INIT, b);
                end else begin
                    fails = 2'd0;
                end
            end
            crcfr_pkg::PH_LEN: begin
                left = b;
                if (b > len_limit) begin
                    phase       = crcfr_pkg::PH_START;
                    r.event_res = crcfr_pkg::EV_LEN_REJ;
                end else begin
                    phase   = crcfr_pkg::PH_PAYLOAD;
                    len_q   = b;
                    crc_acc = arc_fold(crc_acc, b);
                end
            end
            crcfr_pkg::PH_PAYLOAD: begin
                if (left != 8'h00) begin
                    left        = left - 8'd1;
                    crc_acc     = arc_fold(crc_acc, b);
                    r.event_res = crcfr_pkg::EV_DATA;
                    r.data_byte = b;
                end else begin
                    phase   = crcfr_pkg::PH_CRC_LO;
                    hi_byte = b;
                end
            end
            default: begin
                phase = crcfr_pkg::PH_START;
                if (crc_acc == {hi_byte, b}) begin
                    fails       = 2'd0;
                    r.event_res = crcfr_pkg::EV_GOOD;
                end else begin
                    fails       = fails + 2'd1;
                    r.event_res = crcfr_pkg::EV_CRC_BAD;
                    if (fails > 2'd1) begin
                        r.resync = 1'b1;
                        fails    = 2'd0;
                    end
                end
            end
        endcase
        r.frame_cmd  = cmd_q;
        r.frame_len  = (r.event_res == crcfr_pkg::EV_LEN_REJ) ? b : len_q;
        r.fail_count = fails[0];
    endtask

    always @(posedge i_clk) begin
        crcfr_pkg::t_result want;
        crcfr_pkg::t_result made;
        if (!i_rst_n) begin
            phase     = crcfr_pkg::PH_START;
            len_limit = crcfr_pkg::MAX_LENGTH_RST;
            left      = 8'h00;
            hi_byte   = 8'h00;
            cmd_q     = 8'h00;
            len_q     = 8'h00;
            crc_acc   = crcfr_pkg::CRC_INIT;
            fails     = 2'd0;
            frame_events_q.delete();
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                len_limit = i_cfg_mon.max_length;
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                parse_byte(i_in_mon.rx_byte, made);
                frame_events_q.push_back(made);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (frame_events_q.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    want = frame_events_q.pop_front();
                    if (i_out_mon.event_res !== want.event_res) begin
                        report($sformatf("event_res got %0d want %0d",
                                         i_out_mon.event_res, want.event_res));
                    end
                    if (i_out_mon.data_byte !== want.data_byte) begin
                        report($sformatf("data_byte got %02h want %02h",
                                         i_out_mon.data_byte, want.data_byte));
                    end
                    if (i_out_mon.frame_cmd !== want.frame_cmd) begin
                        report($sformatf("frame_cmd got %02h want %02h",
                                         i_out_mon.frame_cmd, want.frame_cmd));
                    end
                    if (i_out_mon.frame_len !== want.frame_len) begin
                        report($sformatf("frame_len got %0d want %0d",
                                         i_out_mon.frame_len, want.frame_len));
                    end
                    if (i_out_mon.fail_count !== want.fail_count) begin
                        report($sformatf("fail_count got %b want %b",
                                         i_out_mon.fail_count, want.fail_count));
                    end
                    if (i_out_mon.resync !== want.resync) begin
                        report($sformatf("resync got %b want %b",
                                         i_out_mon.resync, want.resync));
                    end
                end
            end
        end
        o_pending <= frame_events_q.size();
    end

endmodule

// File: bench/crc16_serial_frame_receiver_top_tb.sv
`timescale 1ns / 1ps

module crc16_serial_frame_receiver_top_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BYTES = 60;

    logic clk = 1'b0;
    logic rst_n;

    crcfr_in_if  in_bus ();
    crcfr_cfg_if cfg_bus ();
    crcfr_out_if out_bus ();

    int         chk_errors;
    int         chk_pending;
    int         sent_bytes = 0;
    int         idle_cycles = 0;
    int         rdy_hold = 0;
    int         rdy_roll;
    logic       calm = 1'b0;
    logic [7:0] limit_now = 8'd20;
    logic [7:0] payload_q[$];
    logic [7:0] plan[6];

    crc16_serial_frame_receiver_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    crcfr_checker chk (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in_mon  (in_bus),
        .i_cfg_mon (cfg_bus),
        .i_out_mon (out_bus),
        .o_errors  (chk_errors),
        .o_pending (chk_pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result-side backpressure
    always @(posedge clk) begin
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
            rdy_hold <= 0;
        end else if (calm) begin
            out_bus.ready <= 1'b1;
            rdy_hold <= 0;
        end else if (rdy_hold != 0) begin
            rdy_hold <= rdy_hold - 1;
        end else begin
            rdy_roll = $urandom_range(0, 99);
            if (rdy_roll < 60) begin
                out_bus.ready <= 1'b1;
                rdy_hold <= $urandom_range(0, 6);
            end else if (rdy_roll < 92) begin
                out_bus.ready <= 1'b0;
                rdy_hold <= $urandom_range(0, 2);
            end else begin
                out_bus.ready <= 1'b0;
                rdy_hold <= $urandom_range(8, 40);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_bus.valid && in_bus.ready) || (cfg_bus.valid && cfg_bus.ready)
            || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("crc16_serial_frame_receiver_top_tb failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_len(input logic [7:0] lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return 8'($urandom_range(0, (lim < 6) ? lim : 6));
        end
        if (r < 95) begin
            return 8'($urandom_range(0, (lim < 24) ? lim : 24));
        end
        return (lim < 32) ? lim : 8'd32;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.rx_byte <= b;
        do @(posedge clk); while (!in_bus.ready);
        sent_bytes++;
    endtask

    task automatic drain();
        in_bus.valid <= 1'b0;
        do @(posedge clk); while (chk_pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.max_length <= v;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        limit_now = v;
    endtask

    // frame built from payload_q
    task automatic send_frame(input logic [7:0] cmd, input logic bad_crc);
        logic [15:0] crc;
        logic [7:0]  len;
        len = 8'(payload_q.size());
        crc = chk.arc_fold(16'h0000, cmd);
        send_byte(cmd);
        crc = chk.arc_fold(crc, len);
        send_byte(len);
        for (int i = 0; i < payload_q.size(); i++) begin
            crc = chk.arc_fold(crc, payload_q[i]);
            send_byte(payload_q[i]);
        end
        if (bad_crc) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
    endtask

    task automatic fill_payload(input int n);
        payload_q.delete();
        repeat (n) payload_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic random_unit();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            fill_payload(pick_len(limit_now));
            send_frame(8'($urandom_range(1, 255)), 1'b0);
        end else if (r < 80) begin
            fill_payload(pick_len(limit_now));
            send_frame(8'($urandom_range(1, 255)), 1'b1);
        end else if (r < 88 && limit_now != 8'hFF) begin
            send_byte(8'($urandom_range(1, 255)));
            send_byte(8'($urandom_range(limit_now + 1, 255)));
        end else if (r < 92) begin
            repeat ($urandom_range(1, 2)) send_byte(8'h00);
        end else if (r < 96) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else begin
            // truncated frame, the next unit runs into it
            k = pick_len(limit_now);
            send_byte(8'($urandom_range(1, 255)));
            send_byte(8'(k));
            repeat ($urandom_range(0, k)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int  target;
        bit  paused;
        rst_n              = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.rx_byte     = 8'h00;
        cfg_bus.valid      = 1'b0;
        cfg_bus.max_length = 8'h00;
        paused             = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00);
        payload_q.delete();
        send_frame(8'hFF, 1'b0);
        send_byte(8'h01);
        send_byte(8'd21);
        payload_q.delete();
        payload_q.push_back(8'h00);
        send_frame(8'h80, 1'b1);
        payload_q.delete();
        payload_q.push_back(8'hFF);
        payload_q.push_back(8'hAA);
        send_frame(8'h7F, 1'b1);
        payload_q.delete();
        send_frame(8'h55, 1'b1);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'hFF);

        plan[0] = 8'd0;
        plan[1] = 8'd255;
        plan[2] = 8'd1;
        plan[3] = 8'd20;
        plan[4] = 8'($urandom_range(0, 255));
        plan[5] = 8'($urandom_range(0, 255));
        for (int p = 0; p < 6; p++) begin
            drain();
            write_limit(plan[p]);
            calm   = (p == 3);
            target = sent_bytes + PHASE_BYTES;
            if (p == 1) begin
                fill_payload(255);
                send_frame(8'($urandom_range(1, 255)), 1'b0);
                target = sent_bytes + PHASE_BYTES;
            end
            while (sent_bytes < target) begin
                random_unit();
                if (p == 4 && !paused && sent_bytes >= target - PHASE_BYTES / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end
        calm = 1'b0;
        drain();

        if (chk_errors == 0 && chk_pending == 0) begin
            $display("crc16_serial_frame_receiver_top_tb passed");
        end else begin
            $display("crc16_serial_frame_receiver_top_tb failed");
        end
        $finish;
    end

endmodule
